/* rtl/bft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types, constants and a helper function for the two-hash bloom filter.
// ----------------------------------------------------------------------------
package bft_pkg;

    localparam int CAP_W          = 17;
    localparam int CHAR_W         = 8;
    localparam int MAP_BITS_DEF   = 65536;
    localparam int HASH_WIDTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } t_key_cmd;

    typedef struct packed {
        logic clr_step;
        logic hash_upd;
        logic div_init;
        logic div_step;
        logic wr_i0;
        logic wr_i1;
        logic rd_i0;
        logic rd_i1;
        logic cap_bit0;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic key_end;
        logic clr_last;
        logic out_busy;
    } t_dp_sts;

    // one restoring step of a remainder against the modulus
    function automatic logic [CAP_W-1:0] mod_step(
        input logic [CAP_W-1:0] rem,
        input logic             bit_in,
        input logic [CAP_W-1:0] modulus
    );
        logic [CAP_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, modulus}) begin
            t = t - {1'b0, modulus};
        end
        return t[CAP_W-1:0];
    endfunction

endpackage

/* rtl/bft_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bft_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bft_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_ctrl
// Sequencer: store clearing, key intake, modulo reduction, store access, result load.
// ----------------------------------------------------------------------------
module bft_ctrl #(
    parameter int HASH_WIDTH = bft_pkg::HASH_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_find,
    input  bft_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output bft_pkg::t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(HASH_WIDTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_WR0,
        S_WR1,
        S_RD0,
        S_RD1,
        S_RES
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_find, n_find;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_find  = r_find;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.hash_upd = w_accept && !i_sts.key_end;
                o_cmd.div_init = w_accept && i_sts.key_end;
                if (w_accept && i_sts.key_end) begin
                    n_state = S_DIV;
                    n_cnt   = CNT_W'(HASH_WIDTH - 1);
                    n_find  = (i_find == bft_pkg::CMD_FIND);
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = r_find ? S_RD0 : S_WR0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_WR0: begin
                o_cmd.wr_i0 = 1'b1;
                n_state     = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr_i1 = 1'b1;
                n_state     = S_IDLE;
            end
            S_RD0: begin
                o_cmd.rd_i0 = 1'b1;
                n_state     = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_i1    = 1'b1;
                o_cmd.cap_bit0 = 1'b1;
                n_state        = S_RES;
            end
            S_RES: begin
                o_cmd.load_out = !i_sts.out_busy;
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_find  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_find  <= n_find;
        end
    end

`ifndef SYNTHESIS
    a_store_ops_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_step, o_cmd.wr_i0, o_cmd.wr_i1, o_cmd.rd_i0, o_cmd.rd_i1}))
        else $error("more than one store operation in a cycle");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_busy)
        else $error("result loaded over an untaken item");

    a_div_follows_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_init |=> (o_cmd.div_step && !o_in_ready))
        else $error("reduction did not start after key end");
`endif

endmodule

/* rtl/bft_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_dp
// Datapath: running hashes, bit-serial modulo units, bit store, result item.
// ----------------------------------------------------------------------------
module bft_dp #(
    parameter int MAP_BITS   = bft_pkg::MAP_BITS_DEF,
    parameter int HASH_WIDTH = bft_pkg::HASH_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bft_pkg::t_dp_cmd            i_cmd,
    output bft_pkg::t_dp_sts            o_sts,
    input  logic [bft_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_cfg_wr_en,
    input  logic [bft_pkg::CAP_W-1:0]   i_cfg_wr_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found
);

    localparam int                IDX_W     = $clog2(MAP_BITS);
    localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(MAP_BITS - 1);
    localparam logic [31:0]       MAP_BITS_W = 32'(MAP_BITS);

    logic [HASH_WIDTH-1:0]     r_bkdr, r_sdbm;
    logic [HASH_WIDTH-1:0]     n_bkdr, n_sdbm;
    logic [bft_pkg::CAP_W-1:0] r_cap, r_cap_eff, w_cap_eff;
    logic [bft_pkg::CAP_W-1:0] r_rem0, r_rem1;
    logic [IDX_W-1:0]          r_clr_addr;
    logic                      r_bit0;
    logic                      r_out_valid;
    logic                      r_found;
    logic [31:0]               w_rem0_ext, w_rem1_ext;
    logic [IDX_W-1:0]          w_idx0, w_idx1;
    logic [HASH_WIDTH-1:0]     w_char_ext;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr, w_raddr;
    logic [0:0]                w_wdata, w_rdata;

    assign w_char_ext = HASH_WIDTH'(i_char);
    assign n_bkdr = (r_bkdr << 7) + (r_bkdr << 1) + r_bkdr + w_char_ext;
    assign n_sdbm = (r_sdbm << 16) + (r_sdbm << 6) - r_sdbm + w_char_ext;

    always_comb begin
        priority if (r_cap == '0) begin
            w_cap_eff = bft_pkg::CAP_W'(1);
        end else if (32'(r_cap) > MAP_BITS_W) begin
            w_cap_eff = MAP_BITS_W[bft_pkg::CAP_W-1:0];
        end else begin
            w_cap_eff = r_cap;
        end
    end

    assign w_rem0_ext = 32'(r_rem0);
    assign w_rem1_ext = 32'(r_rem1);
    assign w_idx0     = w_rem0_ext[IDX_W-1:0];
    assign w_idx1     = w_rem1_ext[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= bft_pkg::CAP_RESET;
            r_bkdr      <= '0;
            r_sdbm      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.hash_upd) begin
                r_bkdr <= n_bkdr;
                r_sdbm <= n_sdbm;
            end else if (i_cmd.div_step) begin
                r_bkdr <= r_bkdr << 1;
                r_sdbm <= r_sdbm << 1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_cap_eff <= w_cap_eff;
            r_rem0    <= '0;
            r_rem1    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem0 <= bft_pkg::mod_step(r_rem0, r_bkdr[HASH_WIDTH-1], r_cap_eff);
            r_rem1 <= bft_pkg::mod_step(r_rem1, r_sdbm[HASH_WIDTH-1], r_cap_eff);
        end
        if (i_cmd.cap_bit0) begin
            r_bit0 <= w_rdata[0];
        end
        if (i_cmd.load_out) begin
            r_found <= r_bit0 & w_rdata[0];
        end
    end

    always_comb begin
        priority if (i_cmd.clr_step) begin
            w_waddr = r_clr_addr;
        end else if (i_cmd.wr_i0) begin
            w_waddr = w_idx0;
        end else begin
            w_waddr = w_idx1;
        end
    end

    assign w_we    = i_cmd.clr_step | i_cmd.wr_i0 | i_cmd.wr_i1;
    assign w_wdata = {!i_cmd.clr_step};
    assign w_raddr = i_cmd.rd_i0 ? w_idx0 : w_idx1;

    bft_ram #(
        .WIDTH (1),
        .DEPTH (MAP_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_i0 | i_cmd.rd_i1),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.key_end  = (i_char == '0);
    assign o_sts.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;

`ifndef SYNTHESIS
    a_hash_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_cmd.div_step) |-> (r_bkdr == '0 && r_sdbm == '0))
        else $error("running hashes not clear after reduction");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_i0 || i_cmd.rd_i0) |-> (r_rem0 < r_cap_eff && r_rem1 < r_cap_eff))
        else $error("bit index not below capacity");
`endif

endmodule

/* rtl/bloom_filter_two_hash_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_two_hash_top
// Two-hash (BKDR and SDBM) bloom filter fed one key byte per item.
//
// Input stream: one key byte per item in s_axis_tdata, command in
// s_axis_tuser (0 insert, 1 find). A zero byte ends the key.
// Output stream: one item per find, found in m_axis_tdata bit 0.
// Config: i_cfg_wr_en/i_cfg_wr_data write the capacity (0 acts as 1,
// values above MAP_BITS act as MAP_BITS); write only while idle.
// Key bytes are taken back to back while s_axis_tready is high. A key end
// starts a bit-serial modulo reduction (both hashes in parallel), then two
// store writes for insert or two store reads plus a result step for find;
// m_axis_tvalid is registered and rises after the result step loads the item.
// The bit store's single write port and single read port set the tail.
// Reset: a clearing pass writes every store bit to zero, address by address,
// with s_axis_tready low; capacity writes are taken during it.
// A stalled output holds its item; the block keeps taking key bytes and
// inserts, and a second find waits until the pending item is taken.
// ----------------------------------------------------------------------------
module bloom_filter_two_hash_top #(
    parameter int MAP_BITS   = bft_pkg::MAP_BITS_DEF,
    parameter int HASH_WIDTH = bft_pkg::HASH_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] character
    input  logic                      s_axis_tuser,  // [0] command
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [0] found, [7:1] zero
    input  logic                      i_cfg_wr_en,
    input  logic [bft_pkg::CAP_W-1:0] i_cfg_wr_data
);

    bft_pkg::t_dp_cmd w_cmd;
    bft_pkg::t_dp_sts w_sts;
    logic             w_found;

    bft_ctrl #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_find     (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    bft_dp #(
        .MAP_BITS   (MAP_BITS),
        .HASH_WIDTH (HASH_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_char        (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_found       (w_found)
    );

    assign m_axis_tdata = {7'b0, w_found};

endmodule

/* test/bloom_filter_two_hash_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_two_hash_top_test
// Self-checking bench for the two-hash bloom filter. Keys go in one byte per
// item with a random-burst sender, and found items come out to a receiver that
// stalls on its own schedule. A local filter model with its own hashes,
// capacity and bit store predicts each find. The run starts with directed
// cases (empty key, extreme bytes, capacity zero and saturation, capacity
// change with a key half sent), then random insert/find traffic over a series
// of capacity settings.
// ----------------------------------------------------------------------------
module bloom_filter_two_hash_top_test;

    localparam int MAX_KEY       = 8;
    localparam int POOL_SIZE     = 32;
    localparam int ITEM_TARGET   = 850;
    localparam int SETTLE_CYCLES = bft_pkg::HASH_WIDTH_DEF + 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 12;

    typedef struct packed {
        logic [MAX_KEY-1:0][7:0] bytes;
        logic [3:0]              len;
    } t_key;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;   // [7:0] character
    logic                      s_axis_tuser;   // [0] command
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;   // [0] found, [7:1] zero
    logic                      i_cfg_wr_en;
    logic [bft_pkg::CAP_W-1:0] i_cfg_wr_data;

    logic [bft_pkg::HASH_WIDTH_DEF-1:0] bkdr_hash;
    logic [bft_pkg::HASH_WIDTH_DEF-1:0] sdbm_hash;
    logic [bft_pkg::CAP_W-1:0]          capacity;
    bit                                 filter_bits [bft_pkg::MAP_BITS_DEF];
    logic                               found_q [$];
    logic                               expected_found;
    t_key                               key_pool [POOL_SIZE];
    t_key                               probe_key;
    int                                 pool_count    = 0;
    int                                 burst_left    = 0;
    int                                 items_sent    = 0;
    int                                 keys_inserted = 0;
    int                                 keys_found    = 0;
    int                                 keys_missed   = 0;
    int                                 mismatches    = 0;
    int                                 cycle_count   = 0;
    int                                 stall_mode    = 0;
    int                                 stall_left    = 0;

    bloom_filter_two_hash_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d finds outstanding", $time, found_q.size());
            $display("bloom_filter_two_hash_top_test: FAIL");
            $finish;
        end
    end

    function automatic logic [bft_pkg::CAP_W-1:0] modulus_in_force();
        if (capacity == '0) begin
            return bft_pkg::CAP_W'(1);
        end
        if (capacity > bft_pkg::MAP_BITS_DEF) begin
            return bft_pkg::CAP_W'(bft_pkg::MAP_BITS_DEF);
        end
        return capacity;
    endfunction

    function automatic void advance_filter(input bft_pkg::t_key_cmd cmd, input logic [7:0] ch);
        logic [bft_pkg::HASH_WIDTH_DEF-1:0] modulus;
        logic [bft_pkg::HASH_WIDTH_DEF-1:0] idx_bkdr;
        logic [bft_pkg::HASH_WIDTH_DEF-1:0] idx_sdbm;
        if (ch != 8'd0) begin
            bkdr_hash = bkdr_hash * 64'd131 + {56'd0, ch};
            sdbm_hash = sdbm_hash * 64'd65599 + {56'd0, ch};
        end else begin
            modulus  = bft_pkg::HASH_WIDTH_DEF'(modulus_in_force());
            idx_bkdr = bkdr_hash % modulus;
            idx_sdbm = sdbm_hash % modulus;
            if (cmd == bft_pkg::CMD_INSERT) begin
                filter_bits[int'(idx_bkdr)] = 1'b1;
                filter_bits[int'(idx_sdbm)] = 1'b1;
            end else begin
                found_q.push_back(filter_bits[int'(idx_bkdr)] && filter_bits[int'(idx_sdbm)]);
            end
            bkdr_hash = '0;
            sdbm_hash = '0;
        end
    endfunction

    function automatic t_key random_key();
        t_key key;
        key = '0;
        case ($urandom_range(0, 15))
            0: begin
                key.len = '0;
            end
            1: begin
                key.len = 4'(MAX_KEY);
            end
            default: begin
                key.len = 4'($urandom_range(1, 5));
            end
        endcase
        for (int i = 0; i < MAX_KEY; i++) begin
            key.bytes[i] = 8'($urandom_range(1, 255));
        end
        return key;
    endfunction

    task automatic send_item(input bft_pkg::t_key_cmd cmd, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1: begin
                    gap = 0;
                end
                7: begin
                    gap = $urandom_range(10, 30);
                end
                default: begin
                    gap = $urandom_range(1, 6);
                end
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        advance_filter(cmd, ch);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_key(input bft_pkg::t_key_cmd cmd, input t_key key);
        for (int i = 0; i < key.len; i++) begin
            send_item(bft_pkg::t_key_cmd'($urandom_range(0, 1)), key.bytes[i]);
        end
        send_item(cmd, 8'd0);
        if (cmd == bft_pkg::CMD_INSERT) begin
            keys_inserted++;
        end
    endtask

    // drop valid, let every find come out, then let a trailing insert finish
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (found_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [bft_pkg::CAP_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        capacity = value;
        @(negedge i_clk);
    endtask

    // receiver: runs of full rate, light stalls and heavy stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (found_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual tdata %02h",
                         $time, m_axis_tdata);
            end else begin
                expected_found = found_q.pop_front();
                if (m_axis_tdata !== {7'd0, expected_found}) begin
                    mismatches++;
                    $display("%0t: found mismatch, expected %02h, actual %02h",
                             $time, {7'd0, expected_found}, m_axis_tdata);
                end
                if (expected_found) begin
                    keys_found++;
                end else begin
                    keys_missed++;
                end
            end
        end
    end

    task automatic test_empty_key();
        t_key empty;
        empty = '0;
        send_key(bft_pkg::CMD_FIND, empty);
        send_key(bft_pkg::CMD_INSERT, empty);
        send_key(bft_pkg::CMD_FIND, empty);
    endtask

    task automatic test_known_key();
        t_key reversed;
        probe_key          = '0;
        probe_key.len      = 4'd3;
        probe_key.bytes[0] = 8'hFF;
        probe_key.bytes[1] = 8'h80;
        probe_key.bytes[2] = 8'h01;
        reversed           = probe_key;
        reversed.bytes[0]  = 8'h01;
        reversed.bytes[2]  = 8'hFF;
        send_key(bft_pkg::CMD_INSERT, probe_key);
        send_key(bft_pkg::CMD_FIND, probe_key);
        send_key(bft_pkg::CMD_FIND, reversed);
        key_pool[0] = probe_key;
        pool_count  = 1;
        wait_for_idle();
    endtask

    // capacity change between the key bytes and the terminator
    task automatic test_capacity_in_flight();
        send_item(bft_pkg::CMD_INSERT, 8'h55);
        send_item(bft_pkg::CMD_FIND, 8'hAA);
        wait_for_idle();
        write_capacity('0);
        send_item(bft_pkg::CMD_FIND, 8'd0);
        wait_for_idle();
    endtask

    task automatic test_capacity_saturation();
        write_capacity('1);
        send_key(bft_pkg::CMD_FIND, probe_key);
        wait_for_idle();
    endtask

    task automatic test_random_phases();
        logic [bft_pkg::CAP_W-1:0] caps [PHASES];
        t_key                      key;
        int                        phase_end;
        caps = '{17'd1, 17'd2, 17'd3, 17'd65537, 17'd7, 17'd100, 17'd1000,
                 17'd4096, 17'd65535, 17'd131071, 17'd0, 17'd65536};
        caps[$urandom_range(4, 8)] = bft_pkg::CAP_W'($urandom_range(1, 131071));
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(caps[p]);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (PHASES - p);
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        key = random_key();
                        send_key(bft_pkg::CMD_INSERT, key);
                        if (pool_count < POOL_SIZE) begin
                            key_pool[pool_count] = key;
                            pool_count++;
                        end else begin
                            key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
                        end
                    end
                    4, 5, 6: begin
                        send_key(bft_pkg::CMD_FIND,
                                 key_pool[$urandom_range(0, pool_count - 1)]);
                    end
                    default: begin
                        send_key(bft_pkg::CMD_FIND, random_key());
                    end
                endcase
            end
            wait_for_idle();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bft_pkg::CMD_INSERT;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        capacity      = bft_pkg::CAP_RESET;
        bkdr_hash     = '0;
        sdbm_hash     = '0;
        for (int i = 0; i < bft_pkg::MAP_BITS_DEF; i++) begin
            filter_bits[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_key();
        test_known_key();
        test_capacity_in_flight();
        test_capacity_saturation();
        test_random_phases();
        wait_for_idle();

        $display("Sent %0d items over %0d capacity settings: %0d inserts, %0d finds checked",
                 items_sent, PHASES + 3, keys_inserted, keys_found + keys_missed);
        $display("Finds: %0d hit, %0d miss; mismatches: %0d",
                 keys_found, keys_missed, mismatches);
        if (mismatches == 0 && found_q.size() == 0) begin
            $display("bloom_filter_two_hash_top_test: PASS");
        end else begin
            $display("bloom_filter_two_hash_top_test: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bft_pkg.sv
rtl/bft_ram.sv
rtl/bft_ctrl.sv
rtl/bft_dp.sv
rtl/bloom_filter_two_hash_top.sv
test/bloom_filter_two_hash_top_test.sv
